[rtl/sis_pkg.sv]
package sis_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned CAPACITY_DEF    = 32;
	localparam int unsigned VALUE_WIDTH_DEF = 16;

	// Fixed widths of the request and result fields.
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned ELEM_W   = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_MEMBER = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_RESOLVE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_WR,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// Outcome of the shared comparator: stored entry against the key.
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

[rtl/sis_ram.sv]
module sis_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/sis_cmp.sv]
module sis_cmp #(
	parameter int unsigned WIDTH = 16
) (
	input  logic [WIDTH-1:0] entry,
	input  logic [WIDTH-1:0] key,
	output sis_pkg::cmp_res_t res
);

	// Unsigned magnitude compare of one stored entry against the search key.
	always_comb begin
		res.lt = (entry < key);
		res.eq = (entry == key);
	end

endmodule

[rtl/sis_seq.sv]
module sis_seq #(
	parameter int unsigned CAPACITY    = sis_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = sis_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sis_pkg::KIND_W-1:0]    kind,
	input  logic [sis_pkg::VALUE_W-1:0]   value,
	input  logic [sis_pkg::POS_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [sis_pkg::COUNT_W-1:0]   count,
	output logic [sis_pkg::ELEM_W-1:0]    element,
	output logic                          full_res,
	output logic                          ram_wr_en,
	output logic [$clog2(CAPACITY)-1:0]   ram_wr_addr,
	output logic [VALUE_WIDTH-1:0]        ram_wr_data,
	output logic                          ram_rd_en,
	output logic [$clog2(CAPACITY)-1:0]   ram_rd_addr,
	input  logic [VALUE_WIDTH-1:0]        ram_rd_data,
	output logic [VALUE_WIDTH-1:0]        cmp_key,
	input  sis_pkg::cmp_res_t             cmp_res
);

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > sis_pkg::POS_W) ? CW : sis_pkg::POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	sis_pkg::state_t state_q, state_d;
	sis_pkg::kind_t  kind_q, kind_d;
	sis_pkg::kind_t  kind_in;
	logic [VALUE_WIDTH-1:0]     value_q, value_d;
	logic [CW-1:0]              count_q, count_d;
	logic [CW-1:0]              idx_q, idx_d;
	logic [CW-1:0]              sh_q, sh_d;
	logic [CW-1:0]              sh_m1;
	logic                       res_found_q, res_found_d;
	logic                       res_full_q, res_full_d;
	logic [sis_pkg::ELEM_W-1:0] res_elem_q, res_elem_d;
	logic                       out_valid_q;
	logic                       found_q, full_q;
	logic [sis_pkg::COUNT_W-1:0] count_out_q;
	logic [sis_pkg::ELEM_W-1:0] element_q;
	logic                       out_free;
	logic                       out_load;

	assign kind_in  = sis_pkg::kind_t'(kind);
	assign sh_m1    = sh_q - CW'(1);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == sis_pkg::ST_DONE) && out_free;
	assign cmp_key  = value_q;

	always_comb begin
		state_d     = state_q;
		kind_d      = kind_q;
		value_d     = value_q;
		count_d     = count_q;
		idx_d       = idx_q;
		sh_d        = sh_q;
		res_found_d = res_found_q;
		res_full_d  = res_full_q;
		res_elem_d  = res_elem_q;
		in_stall    = 1'b1;
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_q[AW-1:0];
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q[AW-1:0];
		ram_wr_data = value_q;

		unique case (state_q)
			sis_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					kind_d      = kind_in;
					value_d     = VALUE_WIDTH'(value);
					idx_d       = '0;
					res_found_d = 1'b0;
					res_full_d  = 1'b0;
					res_elem_d  = '0;
					unique case (kind_in) inside
						sis_pkg::KIND_INSERT, sis_pkg::KIND_MEMBER: begin
							state_d = sis_pkg::ST_SCAN_RD;
						end
						sis_pkg::KIND_CLEAR: begin
							count_d = '0;
							state_d = sis_pkg::ST_DONE;
						end
						default: begin
							if (CMPW'(position) < CMPW'(count_q)) begin
								ram_rd_en   = 1'b1;
								ram_rd_addr = AW'(position);
								state_d     = sis_pkg::ST_READ_WAIT;
							end else begin
								state_d = sis_pkg::ST_DONE;
							end
						end
					endcase
				end
			end
			sis_pkg::ST_SCAN_RD: begin
				if (idx_q == count_q) begin
					state_d = sis_pkg::ST_RESOLVE;
				end else begin
					ram_rd_en = 1'b1;
					state_d   = sis_pkg::ST_SCAN_CMP;
				end
			end
			sis_pkg::ST_SCAN_CMP: begin
				if (cmp_res.lt) begin
					idx_d   = idx_q + CW'(1);
					state_d = sis_pkg::ST_SCAN_RD;
				end else if (cmp_res.eq) begin
					res_found_d = 1'b1;
					state_d     = sis_pkg::ST_DONE;
				end else begin
					state_d = sis_pkg::ST_RESOLVE;
				end
			end
			sis_pkg::ST_RESOLVE: begin
				// The key is absent and idx_q holds its sorted slot.
				if (kind_q == sis_pkg::KIND_MEMBER) begin
					state_d = sis_pkg::ST_DONE;
				end else if (count_q == CAP_C) begin
					res_full_d = 1'b1;
					state_d    = sis_pkg::ST_DONE;
				end else begin
					sh_d    = count_q;
					state_d = (count_q == idx_q) ? sis_pkg::ST_INS_WR : sis_pkg::ST_SHIFT_RD;
				end
			end
			sis_pkg::ST_SHIFT_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = sh_m1[AW-1:0];
				state_d     = sis_pkg::ST_SHIFT_WR;
			end
			sis_pkg::ST_SHIFT_WR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = sh_q[AW-1:0];
				ram_wr_data = ram_rd_data;
				sh_d        = sh_m1;
				state_d     = (sh_m1 == idx_q) ? sis_pkg::ST_INS_WR : sis_pkg::ST_SHIFT_RD;
			end
			sis_pkg::ST_INS_WR: begin
				ram_wr_en = 1'b1;
				count_d   = count_q + CW'(1);
				state_d   = sis_pkg::ST_DONE;
			end
			sis_pkg::ST_READ_WAIT: begin
				res_found_d = 1'b1;
				res_elem_d  = sis_pkg::ELEM_W'(ram_rd_data);
				state_d     = sis_pkg::ST_DONE;
			end
			sis_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sis_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sis_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sis_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q      <= kind_d;
		value_q     <= value_d;
		idx_q       <= idx_d;
		sh_q        <= sh_d;
		res_found_q <= res_found_d;
		res_full_q  <= res_full_d;
		res_elem_q  <= res_elem_d;
		if (out_load) begin
			found_q     <= res_found_q;
			full_q      <= res_full_q;
			element_q   <= res_elem_q;
			count_out_q <= sis_pkg::COUNT_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign full_res  = full_q;
	assign element   = element_q;
	assign count     = count_out_q;

endmodule

[rtl/sorted_integer_set.sv]
// Sorted integer set: one request at a time, results through a registered output.
// No new request is taken until the previous one has left the sequencer. The scan
// uses a read and a compare state per entry, the shift a read and a write state,
// as the store has one registered read port.
// Reset (arst_n low) empties the set at once; stored values need no clearing.
module sorted_integer_set #(
	parameter int unsigned CAPACITY    = sis_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = sis_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sis_pkg::KIND_W-1:0]  kind,
	input  logic [sis_pkg::VALUE_W-1:0] value,
	input  logic [sis_pkg::POS_W-1:0]   position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [sis_pkg::COUNT_W-1:0] count,
	output logic [sis_pkg::ELEM_W-1:0]  element,
	output logic                        full_res
);

	localparam int unsigned AW = $clog2(CAPACITY);

	// The value store holds the set in ascending order in its lowest entries.
	// Entries at or above the count are never read, so the store has no reset.
	logic                   ram_wr_en;
	logic [AW-1:0]          ram_wr_addr;
	logic [VALUE_WIDTH-1:0] ram_wr_data;
	logic                   ram_rd_en;
	logic [AW-1:0]          ram_rd_addr;
	logic [VALUE_WIDTH-1:0] ram_rd_data;

	// The one comparator is shared by every step of the linear scan.
	logic [VALUE_WIDTH-1:0] cmp_key;
	sis_pkg::cmp_res_t      cmp_res;

	sis_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sis_cmp #(
		.WIDTH (VALUE_WIDTH)
	) u_cmp (
		.entry (ram_rd_data),
		.key   (cmp_key),
		.res   (cmp_res)
	);

	// The sequencer walks the store from the lowest entry until it reaches the
	// first entry not below the key. An insert of a new value then moves the
	// tail up by one, starting at the top, and writes the key into the gap.
	// A new request is taken while the previous result still waits downstream;
	// the sequencer holds off while it works on a request and while its own
	// result waits for the output register.
	sis_seq #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.count       (count),
		.element     (element),
		.full_res    (full_res),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.cmp_key     (cmp_key),
		.cmp_res     (cmp_res)
	);

endmodule
